>>> design/tts_pkg.sv
// Package for the two-level task scheduler: command/status types, operation codes,
// request and result codes shared by the controller and the datapath.
// No dependencies.
package tts_pkg;

  // Request codes carried in the func field of an input beat.
  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_ADMIT    = 2'd1;
  localparam logic [1:0] FUNC_DISPATCH = 2'd2;
  localparam logic [1:0] FUNC_REPORT   = 2'd3;

  // Report outcomes.
  localparam logic [1:0] OC_READY      = 2'd0;
  localparam logic [1:0] OC_BLOCKED    = 2'd1;
  localparam logic [1:0] OC_TERMINATED = 2'd2;
  localparam logic [1:0] OC_INVALID    = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_SLOT     = 3'd1;
  localparam logic [2:0] ST_IDLE        = 3'd2;
  localparam logic [2:0] ST_NOT_RUNNING = 3'd3;
  localparam logic [2:0] ST_BAD_OUTCOME = 3'd4;
  localparam logic [2:0] ST_UNBLOCKED   = 3'd5;

  // Queue codes in a result.
  localparam logic [1:0] Q_HIGH    = 2'd0;
  localparam logic [1:0] Q_LOW     = 2'd1;
  localparam logic [1:0] Q_BLOCKED = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_HIGH_QUANTUM = 2'd0;
  localparam logic [1:0] REG_LOW_QUANTUM  = 2'd1;

  localparam logic [31:0] HIGH_QUANTUM_RST = 32'd10000000;
  localparam logic [31:0] LOW_QUANTUM_RST  = 32'd20000000;

  // Most results a single tick may produce.
  localparam logic [4:0] RESULT_LIMIT = 5'd17;

  // Datapath operations issued by the controller.
  localparam logic [2:0] OP_IDLE       = 3'd0;
  localparam logic [2:0] OP_TICK_ADV   = 3'd1;
  localparam logic [2:0] OP_TICK_SCAN  = 3'd2;
  localparam logic [2:0] OP_ADMIT      = 3'd3;
  localparam logic [2:0] OP_DSP_REQ    = 3'd4;
  localparam logic [2:0] OP_DSP_POP    = 3'd5;
  localparam logic [2:0] OP_REP_CHARGE = 3'd6;
  localparam logic [2:0] OP_REP_END    = 3'd7;

  typedef struct packed {
    logic       latch;
    logic [2:0] op;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

endpackage

>>> design/tts_if.sv
// Handshake interfaces for the task scheduler: request, result and configuration channels.
// No dependencies.
interface tts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] delta_ns;
  logic        high_class;
  logic [1:0]  outcome;
  logic [31:0] burst_ns;
  logic [31:0] block_ns;

  modport source (output valid, func, delta_ns, high_class, outcome, burst_ns, block_ns,
                  input ready);
  modport sink   (input valid, func, delta_ns, high_class, outcome, burst_ns, block_ns,
                  output ready);
endinterface

interface tts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot;
  logic [1:0]  queue;
  logic [31:0] quantum;
  logic [63:0] clock_now;
  logic        last;

  modport source (output valid, status, slot, queue, quantum, clock_now, last,
                  input ready);
  modport sink   (input valid, status, slot, queue, quantum, clock_now, last,
                  output ready);
endinterface

interface tts_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/tts_ctrl.sv
// Controller of the task scheduler: sequences each request through datapath operations.
// Depends on tts_pkg.
module tts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    func_i,
  output logic          in_ready_o,
  output tts_pkg::cmd_t cmd_o,
  input  tts_pkg::sts_t sts_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TICK_A = 3'd1;
  localparam logic [2:0] S_TICK_B = 3'd2;
  localparam logic [2:0] S_ADMIT  = 3'd3;
  localparam logic [2:0] S_DSP_A  = 3'd4;
  localparam logic [2:0] S_DSP_B  = 3'd5;
  localparam logic [2:0] S_REP_A  = 3'd6;
  localparam logic [2:0] S_REP_B  = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o.latch = in_valid_i && (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE:   cmd_o.op = tts_pkg::OP_IDLE;
      S_TICK_A: cmd_o.op = tts_pkg::OP_TICK_ADV;
      S_TICK_B: cmd_o.op = tts_pkg::OP_TICK_SCAN;
      S_ADMIT:  cmd_o.op = tts_pkg::OP_ADMIT;
      S_DSP_A:  cmd_o.op = tts_pkg::OP_DSP_REQ;
      S_DSP_B:  cmd_o.op = tts_pkg::OP_DSP_POP;
      S_REP_A:  cmd_o.op = tts_pkg::OP_REP_CHARGE;
      S_REP_B:  cmd_o.op = tts_pkg::OP_REP_END;
      default:  cmd_o.op = tts_pkg::OP_IDLE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (func_i)
            tts_pkg::FUNC_TICK:     state_d = S_TICK_A;
            tts_pkg::FUNC_ADMIT:    state_d = S_ADMIT;
            tts_pkg::FUNC_DISPATCH: state_d = S_DSP_A;
            tts_pkg::FUNC_REPORT:   state_d = S_REP_A;
            default:                state_d = S_IDLE;
          endcase
        end
      end
      S_TICK_A: state_d = S_TICK_B;
      S_DSP_A:  state_d = S_DSP_B;
      S_REP_A:  state_d = S_REP_B;
      S_TICK_B, S_ADMIT, S_DSP_B, S_REP_B: begin
        if (sts_i.done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/tts_datapath.sv
// Datapath of the task scheduler: clock, slot bitmap, ready FIFOs, blocked list,
// quantum registers and the result register. Depends on tts_pkg.
module tts_datapath #(
  parameter int PROC_SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tts_pkg::cmd_t cmd_i,
  output tts_pkg::sts_t sts_o,
  input  logic [31:0]   delta_ns_i,
  input  logic          high_class_i,
  input  logic [1:0]    outcome_i,
  input  logic [31:0]   burst_ns_i,
  input  logic [31:0]   block_ns_i,
  input  logic          cfg_valid_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [2:0]    status_o,
  output logic [3:0]    slot_o,
  output logic [1:0]    queue_o,
  output logic [31:0]   quantum_o,
  output logic [63:0]   clock_now_o,
  output logic          last_o
);

  localparam int SW = $clog2(PROC_SLOTS);
  localparam int CW = $clog2(PROC_SLOTS + 1);
  localparam logic [SW-1:0] LastIdx = SW'(PROC_SLOTS - 1);
  localparam logic [CW-1:0] CntFull = CW'(PROC_SLOTS);

  function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] p);
    return (p == LastIdx) ? '0 : SW'(p + 1'b1);
  endfunction

  function automatic logic [3:0] to_slot(input logic [SW-1:0] s);
    logic [SW+3:0] t;
    t = {4'b0000, s};
    return t[3:0];
  endfunction

  // Configuration and scheduler state.
  logic [31:0]           hq_q, lq_q;
  logic [63:0]           clock_q;
  logic [PROC_SLOTS-1:0] busy_q;
  logic [PROC_SLOTS-1:0] cls_q;
  logic [63:0]           wake_q [PROC_SLOTS];
  logic [SW-1:0]         hf_q [PROC_SLOTS];
  logic [SW-1:0]         lf_q [PROC_SLOTS];
  logic [SW-1:0]         bl_q [PROC_SLOTS];
  logic [SW-1:0]         hrd_q, hwr_q, lrd_q, lwr_q;
  logic [CW-1:0]         hcnt_q, lcnt_q, bcnt_q;
  logic [SW-1:0]         run_q;
  logic                  runv_q;

  // Latched request.
  logic [31:0] delta_q, burst_q, blk_q;
  logic        io_q;
  logic [1:0]  outcome_q;

  // Scan state for admit and tick.
  logic [SW-1:0] si_q;
  logic [CW-1:0] ri_q, wi_q;
  logic [4:0]    nres_q;
  logic          pv_q;
  logic [SW-1:0] pslot_q;
  logic [1:0]    pq_q;

  // Result register.
  logic        ov_q;
  logic [2:0]  ost_q;
  logic [3:0]  oslot_q;
  logic [1:0]  oq_q;
  logic [31:0] oquant_q;
  logic [63:0] oclk_q;
  logic        olast_q;

  logic          eok;
  logic          e_fire, e_last;
  logic [2:0]    e_status;
  logic [SW-1:0] e_slot;
  logic [1:0]    e_queue;
  logic [31:0]   e_quant;
  logic [63:0]   e_clock;
  logic          done;
  logic          rq_fire, rq_cls;
  logic [SW-1:0] rq_slot;
  logic [1:0]    rq_queue;
  logic          admit_take, si_inc, tk_due, tk_keep, tk_end;
  logic          hpop, lpop, run_set, run_clr, blk_push, free_run;
  logic [SW-1:0] run_d;
  logic          hpush, lpush;
  logic [SW-1:0] hpush_slot;
  logic [63:0]   clock_d, sum_delta, sum_burst, wake_sum;
  logic [SW-1:0] bl_cur;
  logic          in_range, due;

  assign eok       = !ov_q || out_ready_i;
  assign sum_delta = clock_q + {32'd0, delta_q};
  assign sum_burst = clock_q + {32'd0, burst_q};
  assign wake_sum  = clock_q + {32'd0, blk_q};
  assign in_range  = (ri_q < bcnt_q);
  assign bl_cur    = bl_q[ri_q[SW-1:0]];
  assign due       = (wake_q[bl_cur] <= clock_q) && (nres_q < tts_pkg::RESULT_LIMIT);
  assign rq_cls    = cls_q[rq_slot];
  assign rq_queue  = rq_cls ? tts_pkg::Q_HIGH : tts_pkg::Q_LOW;
  assign hpush     = (rq_fire && rq_cls) || admit_take;
  assign hpush_slot = admit_take ? si_q : rq_slot;
  assign lpush     = rq_fire && !rq_cls;

  always_comb begin
    done       = 1'b0;
    e_fire     = 1'b0;
    e_last     = 1'b1;
    e_status   = tts_pkg::ST_OK;
    e_slot     = '0;
    e_queue    = tts_pkg::Q_HIGH;
    e_quant    = '0;
    e_clock    = clock_q;
    rq_fire    = 1'b0;
    rq_slot    = run_q;
    admit_take = 1'b0;
    si_inc     = 1'b0;
    tk_due     = 1'b0;
    tk_keep    = 1'b0;
    tk_end     = 1'b0;
    hpop       = 1'b0;
    lpop       = 1'b0;
    run_set    = 1'b0;
    run_clr    = 1'b0;
    run_d      = run_q;
    blk_push   = 1'b0;
    free_run   = 1'b0;
    clock_d    = clock_q;
    unique case (cmd_i.op)
      tts_pkg::OP_TICK_ADV: begin
        done    = 1'b1;
        clock_d = sum_delta;
      end
      tts_pkg::OP_TICK_SCAN: begin
        if (in_range) begin
          if (!due) begin
            tk_keep = 1'b1;
          end else if (!pv_q || eok) begin
            // Each released slot is held until the next, so only the final one is marked last.
            tk_due   = 1'b1;
            rq_fire  = 1'b1;
            rq_slot  = bl_cur;
            e_fire   = pv_q;
            e_last   = 1'b0;
            e_status = tts_pkg::ST_UNBLOCKED;
            e_slot   = pslot_q;
            e_queue  = pq_q;
          end
        end else if (eok) begin
          done   = 1'b1;
          tk_end = 1'b1;
          e_fire = 1'b1;
          if (pv_q) begin
            e_status = tts_pkg::ST_UNBLOCKED;
            e_slot   = pslot_q;
            e_queue  = pq_q;
          end
        end
      end
      tts_pkg::OP_ADMIT: begin
        if (!busy_q[si_q] || (si_q == LastIdx)) begin
          if (eok) begin
            done   = 1'b1;
            e_fire = 1'b1;
            if (!busy_q[si_q]) begin
              admit_take = 1'b1;
              e_slot     = si_q;
            end else begin
              e_status = tts_pkg::ST_NO_SLOT;
            end
          end
        end else begin
          si_inc = 1'b1;
        end
      end
      tts_pkg::OP_DSP_REQ: begin
        done = 1'b1;
        if (runv_q) begin
          rq_fire = 1'b1;
          run_clr = 1'b1;
        end
      end
      tts_pkg::OP_DSP_POP: begin
        if (eok) begin
          done   = 1'b1;
          e_fire = 1'b1;
          if ((hcnt_q == '0) && (lcnt_q == '0)) begin
            e_status = tts_pkg::ST_IDLE;
          end else begin
            clock_d = sum_delta;
            e_clock = sum_delta;
            run_set = 1'b1;
            if (hcnt_q != '0) begin
              hpop    = 1'b1;
              run_d   = hf_q[hrd_q];
              e_queue = tts_pkg::Q_HIGH;
              e_quant = hq_q;
            end else begin
              lpop    = 1'b1;
              run_d   = lf_q[lrd_q];
              e_queue = tts_pkg::Q_LOW;
              e_quant = lq_q;
            end
            e_slot = run_d;
          end
        end
      end
      tts_pkg::OP_REP_CHARGE: begin
        done = 1'b1;
        if (runv_q && (outcome_q != tts_pkg::OC_INVALID)) clock_d = sum_burst;
      end
      tts_pkg::OP_REP_END: begin
        if (eok) begin
          done   = 1'b1;
          e_fire = 1'b1;
          e_slot = run_q;
          if (!runv_q) begin
            e_status = tts_pkg::ST_NOT_RUNNING;
            e_slot   = '0;
          end else begin
            unique case (outcome_q)
              tts_pkg::OC_READY: begin
                run_clr = 1'b1;
                rq_fire = 1'b1;
                e_queue = rq_queue;
              end
              tts_pkg::OC_BLOCKED: begin
                run_clr  = 1'b1;
                blk_push = 1'b1;
                e_queue  = tts_pkg::Q_BLOCKED;
              end
              tts_pkg::OC_TERMINATED: begin
                run_clr  = 1'b1;
                free_run = 1'b1;
              end
              default: e_status = tts_pkg::ST_BAD_OUTCOME;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  assign sts_o.done = done;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hq_q    <= tts_pkg::HIGH_QUANTUM_RST;
      lq_q    <= tts_pkg::LOW_QUANTUM_RST;
      clock_q <= '0;
      busy_q  <= '0;
      hrd_q   <= '0;
      hwr_q   <= '0;
      lrd_q   <= '0;
      lwr_q   <= '0;
      hcnt_q  <= '0;
      lcnt_q  <= '0;
      bcnt_q  <= '0;
      run_q   <= '0;
      runv_q  <= 1'b0;
      si_q    <= '0;
      ri_q    <= '0;
      wi_q    <= '0;
      nres_q  <= '0;
      pv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == tts_pkg::REG_HIGH_QUANTUM)) hq_q <= cfg_data_i;
      if (cfg_valid_i && (cfg_index_i == tts_pkg::REG_LOW_QUANTUM))  lq_q <= cfg_data_i;
      clock_q <= clock_d;

      if (cmd_i.latch) begin
        si_q   <= '0;
        ri_q   <= '0;
        wi_q   <= '0;
        nres_q <= '0;
        pv_q   <= 1'b0;
      end
      if (si_inc) si_q <= wrap_inc(si_q);
      if (tk_keep) begin
        ri_q <= ri_q + 1'b1;
        wi_q <= wi_q + 1'b1;
      end
      if (tk_due) begin
        ri_q   <= ri_q + 1'b1;
        nres_q <= nres_q + 1'b1;
        pv_q   <= 1'b1;
      end
      if (tk_end) bcnt_q <= wi_q;
      else if (blk_push && (bcnt_q != CntFull)) bcnt_q <= bcnt_q + 1'b1;

      if (admit_take) busy_q[si_q] <= 1'b1;
      if (free_run)   busy_q[run_q] <= 1'b0;

      if (hpush && (hcnt_q != CntFull)) begin
        hwr_q  <= wrap_inc(hwr_q);
        hcnt_q <= hcnt_q + 1'b1;
      end else if (hpop) begin
        hrd_q  <= wrap_inc(hrd_q);
        hcnt_q <= hcnt_q - 1'b1;
      end
      if (lpush && (lcnt_q != CntFull)) begin
        lwr_q  <= wrap_inc(lwr_q);
        lcnt_q <= lcnt_q + 1'b1;
      end else if (lpop) begin
        lrd_q  <= wrap_inc(lrd_q);
        lcnt_q <= lcnt_q - 1'b1;
      end

      if (run_set) begin
        run_q  <= run_d;
        runv_q <= 1'b1;
      end else if (run_clr) begin
        runv_q <= 1'b0;
      end

      if (e_fire)           ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // Payload storage; entries are only read after they have been written.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      delta_q   <= delta_ns_i;
      io_q      <= high_class_i;
      outcome_q <= outcome_i;
      burst_q   <= burst_ns_i;
      blk_q     <= block_ns_i;
    end
    if (admit_take) cls_q[si_q] <= io_q;
    if (hpush && (hcnt_q != CntFull)) hf_q[hwr_q] <= hpush_slot;
    if (lpush && (lcnt_q != CntFull)) lf_q[lwr_q] <= rq_slot;
    // Kept entries are compacted towards the head of the blocked list.
    if (tk_keep) bl_q[wi_q[SW-1:0]] <= bl_cur;
    if (blk_push && (bcnt_q != CntFull)) bl_q[bcnt_q[SW-1:0]] <= run_q;
    if (blk_push) wake_q[run_q] <= wake_sum;
    if (tk_due) begin
      pslot_q <= bl_cur;
      pq_q    <= rq_queue;
    end
    if (e_fire) begin
      ost_q    <= e_status;
      oslot_q  <= to_slot(e_slot);
      oq_q     <= e_queue;
      oquant_q <= e_quant;
      oclk_q   <= e_clock;
      olast_q  <= e_last;
    end
  end

  assign out_valid_o = ov_q;
  assign status_o    = ost_q;
  assign slot_o      = oslot_q;
  assign queue_o     = oq_q;
  assign quantum_o   = oquant_q;
  assign clock_now_o = oclk_q;
  assign last_o      = olast_q;

endmodule

>>> design/two_level_task_scheduler.sv
// Top level of the two-level task scheduler: controller plus datapath.
// Depends on tts_pkg, tts_if, tts_ctrl and tts_datapath.
//
// Requests arrive on in_i (valid/ready); each beat is a tick, admit, dispatch or
// report. Results leave on out_o, one beat each, the final beat of a request
// carrying last. Quantum registers are written on cfg_i (index 0 high, 1 low),
// which is always ready; other indexes are ignored.
// One request is worked on at a time; in_i is ready only while the controller
// is idle. Admit scans the slot bitmap, one slot examined per cycle; dispatch
// and report each run a request step, then a result step; tick advances the
// clock, then scans the blocked list, one entry per cycle while output is free.
// The blocked list scan and the free-slot scan set the rate.
// Results sit in an output register; while the receiver stalls the block
// finishes internal steps but holds before the next result beat, and takes a
// new request once the current one has placed its final beat.
// Reset clears the clock, bitmap, queue counts and running task and restores
// the default quanta; no clearing pass is needed.
module two_level_task_scheduler #(
  parameter int PROC_SLOTS = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  tts_in_if.sink    in_i,
  tts_out_if.source out_o,
  tts_cfg_if.sink   cfg_i
);

  tts_pkg::cmd_t cmd;
  tts_pkg::sts_t sts;
  logic          in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  tts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .func_i     (in_i.func),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  tts_datapath #(
    .PROC_SLOTS (PROC_SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .delta_ns_i   (in_i.delta_ns),
    .high_class_i (in_i.high_class),
    .outcome_i    (in_i.outcome),
    .burst_ns_i   (in_i.burst_ns),
    .block_ns_i   (in_i.block_ns),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .status_o     (out_o.status),
    .slot_o       (out_o.slot),
    .queue_o      (out_o.queue),
    .quantum_o    (out_o.quantum),
    .clock_now_o  (out_o.clock_now),
    .last_o       (out_o.last)
  );

endmodule
